[src/gcw_pkg.sv]
// Shared types, codes and constants of the GC content window block.
`default_nettype none

package gcw_pkg;

  // Input command codes
  localparam logic CMD_SYMBOL = 1'b0;
  localparam logic CMD_EOL    = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPL    = 2'd2;

  localparam logic [8:0] RST_WINDOW = 9'd10;
  localparam logic [8:0] RST_STEP   = 9'd20;
  localparam logic [7:0] RST_BPL    = 8'd80;
  localparam logic [8:0] STEP_MAX   = 9'd256;

  // Payload widths
  localparam int SYMBOL_W   = 8;
  localparam int OUT_LINE_W = 20;
  localparam int OUT_BASE_W = 28;
  localparam int OUT_AVG_W  = 17;
  localparam int COUNT_W    = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Line queue depth between front and back
  localparam int LQ_DEPTH = 2;

  // ASCII base letters, upper case; clearing bit 5 folds lower case onto them
  localparam logic [SYMBOL_W-1:0] CH_A      = 8'h41;
  localparam logic [SYMBOL_W-1:0] CH_T      = 8'h54;
  localparam logic [SYMBOL_W-1:0] CH_C      = 8'h43;
  localparam logic [SYMBOL_W-1:0] CH_G      = 8'h47;
  localparam logic [SYMBOL_W-1:0] CASE_MASK = 8'hDF;

  typedef enum logic [1:0] {
    BASE_OTHER,
    BASE_AT,
    BASE_GC
  } base_class_t;

  typedef struct packed {
    logic [COUNT_W-1:0] gc;
    logic [COUNT_W-1:0] at;
  } line_counts_t;

  typedef struct packed {
    logic [8:0] window_lines;
    logic [8:0] step_lines;
    logic [7:0] bases_per_line;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAC,
    ST_AVG,
    ST_COMMIT
  } back_state_t;

  function automatic base_class_t classify(input logic [SYMBOL_W-1:0] sym);
    logic [SYMBOL_W-1:0] u;
    base_class_t         c;
    u = sym & CASE_MASK;
    unique case (u)
      CH_A, CH_T: c = BASE_AT;
      CH_C, CH_G: c = BASE_GC;
      default:    c = BASE_OTHER;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/gcw_if.sv]
// Valid/ready channel interfaces for sequence input and window results.
`default_nettype none

interface gcw_in_if
  import gcw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                command;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, command, symbol, input ready);
  modport sink   (input valid, command, symbol, output ready);
endinterface

interface gcw_out_if
  import gcw_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OUT_LINE_W-1:0] window_start_line;
  logic [OUT_BASE_W-1:0] base_position;
  logic [OUT_AVG_W-1:0]  gc_average;

  modport source (output valid, window_start_line, base_position, gc_average, input ready);
  modport sink   (input valid, window_start_line, base_position, gc_average, output ready);
endinterface

`default_nettype wire

[src/gc_content_window.sv]
// Top level of the GC content sliding window block.
//
// Usage: sequence characters stream in on in_ch (command 0, symbol = ASCII),
// with an item of command 1 at each line end. A/T and G/C are counted per line,
// case-insensitive; anything else is skipped. Each line end yields a Q1.16 GC
// fraction that enters a ring of the last window_lines lines. A result on
// out_ch (start line, start line * bases_per_line, mean fraction) appears when
// a full window ends on a start line that is a multiple of step_lines.
// Throughput: one character item per cycle while the line queue is not full.
// The back spends longer on a line end that completes a reported window than
// on one that does not, as the one shared bit-serial divider computes both the
// line fraction and the window mean; an empty line skips the fraction divide.
// Two line ends queue; in_ch.ready drops only while the queue is full.
// A stalled out_ch holds one result in its register; the back carries on until
// the next reporting line and waits before committing it.
// Reset (rst_n low, synchronous): registers return to 10 / 20 / 80; counts,
// window sum, line counter and phase clear; the ring is not swept.
// cfg_we writes register cfg_index (0 window, 1 step, 2 bases per line) from
// cfg_data; writing the window restarts the windowing.
`default_nettype none

module gc_content_window
  import gcw_pkg::*;
#(
  parameter int WINDOW_MAX    = 256,
  parameter int LINE_BITS     = 20,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gcw_in_if.sink                in_ch,
  gcw_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t         cfg_r;
  logic         restart;
  logic         q_push, q_full, q_pop, q_empty;
  line_counts_t q_push_data, q_head;

  // A window length write restarts the windowing; line counts in the front
  // are kept.
  assign restart = cfg_we && (cfg_index == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_lines   <= RST_WINDOW;
      cfg_r.step_lines     <= RST_STEP;
      cfg_r.bases_per_line <= RST_BPL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW: cfg_r.window_lines   <= cfg_data;
        REG_STEP:   cfg_r.step_lines     <= cfg_data;
        REG_BPL:    cfg_r.bases_per_line <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front: one character per cycle while the queue is not full, pushes the counts at each line end
  gcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // Queue decoupling counting from the per-line arithmetic
  gcw_lineq u_lineq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: fraction divide, ring update, window mean and result register
  gcw_back #(
    .WINDOW_MAX    (WINDOW_MAX),
    .LINE_BITS     (LINE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .restart    (restart),
    .head       (q_head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

[src/gcw_front.sv]
// Front end: accepts characters, counts A/T and G/C bases, queues line totals.
`default_nettype none

module gcw_front
  import gcw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  gcw_in_if.sink       in_ch,
  input  logic         q_full,
  output logic         push,
  output line_counts_t push_data
);

  logic [COUNT_W-1:0] at_r, at_nxt;
  logic [COUNT_W-1:0] gc_r, gc_nxt;
  logic               accept;
  base_class_t        cls;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cls         = classify(in_ch.symbol);

  assign push         = accept && (in_ch.command == CMD_EOL);
  assign push_data.gc = gc_r;
  assign push_data.at = at_r;

  always_comb begin
    at_nxt = at_r;
    gc_nxt = gc_r;
    if (accept) begin
      if (in_ch.command == CMD_EOL) begin
        at_nxt = '0;
        gc_nxt = '0;
      end else begin
        unique case (cls)
          BASE_AT: begin
            if (at_r != COUNT_MAX) at_nxt = at_r + 1'b1;
          end
          BASE_GC: begin
            if (gc_r != COUNT_MAX) gc_nxt = gc_r + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_r <= '0;
      gc_r <= '0;
    end else begin
      at_r <= at_nxt;
      gc_r <= gc_nxt;
    end
  end

endmodule

`default_nettype wire

[src/gcw_lineq.sv]
// Short queue of finished line counts between front and back.
`default_nettype none

module gcw_lineq
  import gcw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  line_counts_t push_data,
  output logic         full,
  input  logic         pop,
  output line_counts_t head,
  output logic         empty
);

  localparam int AW = (LQ_DEPTH > 1) ? $clog2(LQ_DEPTH) : 1;
  localparam int CW = $clog2(LQ_DEPTH + 1);

  line_counts_t    entry_r [LQ_DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(LQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = entry_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (32'(p) + 32'd1 == 32'(LQ_DEPTH)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wrap_inc(wr_r);
      if (do_pop)  rd_r <= wrap_inc(rd_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

[src/gcw_div.sv]
// Restoring divider, one quotient bit per cycle, remainder seeded by caller.
`default_nettype none

module gcw_div #(
  parameter int DIV_W = 9,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] rem_init,
  input  logic [Q_W-1:0]   low_init,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   trial;
  logic             ge;

  // rem_init < divisor is required, so the trial stays below twice the divisor
  assign trial   = {rem_r, low_r[Q_W-1]};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? DIV_W'(trial - {1'b0, dvs_r}) : DIV_W'(trial);

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      low_r <= low_init;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_r << 1;
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[src/gcw_back.sv]
// Back end: line fraction, fraction ring, window sum, average and result register.
`default_nettype none

module gcw_back
  import gcw_pkg::*;
#(
  parameter int WINDOW_MAX    = 256,
  parameter int LINE_BITS     = 20,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         restart,
  input  line_counts_t head,
  input  logic         head_valid,
  output logic         pop,
  gcw_out_if.source    out_ch
);

  localparam int W_W   = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int Q_W   = FRACTION_BITS + 1;
  localparam int SUM_W = FRACTION_BITS + W_W;
  localparam int DIV_W = (W_W > COUNT_W + 1) ? W_W : COUNT_W + 1;
  localparam int TOT_W = COUNT_W + 1;
  localparam int PRD_W = LINE_BITS + 8;

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  back_state_t state_r, state_nxt;

  logic [PTR_W-1:0]      ptr_r;
  logic [SUM_W-1:0]      sum_r;
  logic [LINE_BITS-1:0]  lc_r;
  logic [7:0]            phase_r;
  logic                  zero_r;
  logic                  emit_r;
  logic [Q_W-1:0]        frac_r;
  logic [Q_W-1:0]        avg_r;
  logic [Q_W-1:0]        ring_q_r;
  logic [OUT_BASE_W-1:0] prod_r;
  logic [LINE_BITS-1:0]  start_r;
  logic                  out_valid_r;
  logic [OUT_LINE_W-1:0] out_line_r;
  logic [OUT_BASE_W-1:0] out_base_r;
  logic [OUT_AVG_W-1:0]  out_avg_r;

  logic [Q_W-1:0] ring_mem [WINDOW_MAX];

  logic [W_W-1:0]       win_eff;
  logic [8:0]           step_eff;
  logic [TOT_W-1:0]     total;
  logic                 full_win;
  logic                 emit_now;
  logic [LINE_BITS-1:0] start_line;
  logic [31:0]          slot_tmp;
  logic [PTR_W-1:0]     rd_addr;
  logic [PTR_W-1:0]     ptr_inc;
  logic [7:0]           phase_inc;
  logic [LINE_BITS-1:0] lc_inc;
  logic [SUM_W-1:0]     sum_nxt;
  logic [PRD_W-1:0]     prod_full;
  logic                 out_free;
  logic                 frac_done;
  logic                 commit;
  logic                 load_out;
  logic                 ring_re;
  logic                 avg_start;

  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_rem, div_dvs;
  logic [Q_W-1:0]   div_low, div_q;

  // Effective register values: zero acts as one, large values clamp
  always_comb begin
    if (cfg.window_lines == '0)                 win_eff = W_W'(1);
    else if (32'(cfg.window_lines) > WINDOW_MAX) win_eff = W_W'(WINDOW_MAX);
    else                                        win_eff = W_W'(cfg.window_lines);
    if (cfg.step_lines == '0)          step_eff = 9'd1;
    else if (cfg.step_lines > STEP_MAX) step_eff = STEP_MAX;
    else                               step_eff = cfg.step_lines;
  end

  assign total      = TOT_W'(head.gc) + TOT_W'(head.at);
  assign full_win   = (32'(lc_r) >= 32'(win_eff));
  assign emit_now   = full_win && (phase_r == '0);
  assign start_line = LINE_BITS'(32'(lc_r) - 32'(win_eff));
  assign prod_full  = PRD_W'(start_line) * PRD_W'(cfg.bases_per_line);

  // Oldest slot of the window: ptr - w modulo the ring depth
  assign slot_tmp = 32'(ptr_r) + 32'(WINDOW_MAX) - 32'(win_eff);
  assign rd_addr  = (slot_tmp >= 32'(WINDOW_MAX)) ? PTR_W'(slot_tmp - 32'(WINDOW_MAX))
                                                  : PTR_W'(slot_tmp);
  assign ptr_inc  = (32'(ptr_r) + 32'd1 == 32'(WINDOW_MAX)) ? '0 : ptr_r + 1'b1;

  assign phase_inc = (9'(phase_r) + 9'd1 >= step_eff) ? '0 : phase_r + 8'd1;
  assign lc_inc    = (lc_r == LINE_MAX) ? lc_r : lc_r + 1'b1;
  assign sum_nxt   = sum_r - (full_win ? SUM_W'(ring_q_r) : '0) + SUM_W'(frac_r);

  assign out_free  = !out_valid_r || out_ch.ready;
  assign frac_done = zero_r || div_done;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (head_valid) state_nxt = ST_FRAC;
      ST_FRAC:   if (frac_done) state_nxt = emit_now ? ST_AVG : ST_COMMIT;
      ST_AVG:    if (div_done) state_nxt = ST_COMMIT;
      ST_COMMIT: if (!emit_r || out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop       = 1'b0;
    ring_re   = 1'b0;
    avg_start = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    div_rem   = DIV_W'(sum_r >> Q_W);
    div_low   = sum_r[Q_W-1:0];
    div_dvs   = DIV_W'(win_eff);
    unique case (state_r)
      ST_IDLE: begin
        pop       = head_valid;
        ring_re   = head_valid;
        div_start = head_valid && (total != '0);
        // gc * 2^F split as (gc >> 1) in the remainder and gc[0] at the top
        div_rem   = DIV_W'(head.gc >> 1);
        div_low   = {head.gc[0], {FRACTION_BITS{1'b0}}};
        div_dvs   = DIV_W'(total);
      end
      ST_FRAC: begin
        avg_start = frac_done && emit_now;
        div_start = avg_start;
      end
      ST_AVG: ;
      ST_COMMIT: commit = !emit_r || out_free;
      default: ;
    endcase
  end

  assign load_out = commit && emit_r;

  gcw_div #(
    .DIV_W (DIV_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      sum_r       <= '0;
      lc_r        <= '0;
      phase_r     <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (restart) begin
        ptr_r   <= '0;
        sum_r   <= '0;
        lc_r    <= '0;
        phase_r <= '0;
      end else if (commit) begin
        ptr_r <= ptr_inc;
        sum_r <= sum_nxt;
        lc_r  <= lc_inc;
        if (full_win) phase_r <= phase_inc;
      end
      if (state_r == ST_FRAC && frac_done) emit_r <= emit_now;
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) zero_r <= (total == '0);
    if (state_r == ST_FRAC && frac_done) frac_r <= zero_r ? '0 : div_q;
    if (avg_start) begin
      prod_r  <= OUT_BASE_W'(prod_full);
      start_r <= start_line;
    end
    if (state_r == ST_AVG && div_done) avg_r <= div_q;
    if (load_out) begin
      out_line_r <= OUT_LINE_W'(start_r);
      out_base_r <= prod_r;
      out_avg_r  <= OUT_AVG_W'(avg_r);
    end
  end

  // Fraction ring: read the leaving slot at pop, write the new line at commit
  always_ff @(posedge clk) begin
    if (commit)  ring_mem[ptr_r] <= frac_r;
    if (ring_re) ring_q_r <= ring_mem[rd_addr];
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.window_start_line = out_line_r;
  assign out_ch.base_position     = out_base_r;
  assign out_ch.gc_average        = out_avg_r;

`ifndef NO_ASSERTIONS
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_avg_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AVG) |-> emit_r)
    else $error("average computed for a line that emits nothing");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("committed window result not presented");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (SUM_W + 1)'(sum_r) <= ((SUM_W + 1)'(win_eff) << FRACTION_BITS))
    else $error("window sum above window length times one");
`endif

endmodule

`default_nettype wire

[bench/gc_window_checker.sv]
// Checker for the GC content window block: predicts every window average and compares.
module gc_window_checker
  import gcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_command,
  input  logic [SYMBOL_W-1:0]   in_symbol,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [OUT_LINE_W-1:0] out_start_line,
  input  logic [OUT_BASE_W-1:0] out_base_position,
  input  logic [OUT_AVG_W-1:0]  out_gc_average,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    windows_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 256;
  localparam logic [OUT_LINE_W-1:0] LINE_SAT = '1;

  typedef struct packed {
    logic [OUT_LINE_W-1:0] start_line;
    logic [OUT_BASE_W-1:0] base_position;
    logic [OUT_AVG_W-1:0]  gc_average;
  } window_avg_t;

  window_avg_t pending_avgs[$];

  logic [8:0]            window_reg;
  logic [8:0]            step_reg;
  logic [7:0]            bpl_reg;
  logic [COUNT_W-1:0]    at_bases;
  logic [COUNT_W-1:0]    gc_bases;
  logic [OUT_AVG_W-1:0]  frac_ring [RING_DEPTH];
  logic [7:0]            ring_head;
  logic [24:0]           frac_sum;
  logic [OUT_LINE_W-1:0] line_idx;
  logic [8:0]            phase_cnt;
  int                    errors = 0;

  function automatic int unsigned span_lines();
    if (window_reg == 0) return 1;
    if (window_reg > RING_DEPTH) return RING_DEPTH;
    return window_reg;
  endfunction

  function automatic int unsigned stride_lines();
    if (step_reg == 0) return 1;
    if (step_reg > STEP_MAX) return STEP_MAX;
    return step_reg;
  endfunction

  function automatic void clear_windowing();
    foreach (frac_ring[i]) frac_ring[i] = '0;
    ring_head = '0;
    frac_sum  = '0;
    line_idx  = '0;
    phase_cnt = '0;
  endfunction

  // Case folded by hand: only the eight letters count
  function automatic void count_base(logic [SYMBOL_W-1:0] sym);
    case (sym)
      "A", "a", "T", "t": if (at_bases != COUNT_MAX) at_bases++;
      "C", "c", "G", "g": if (gc_bases != COUNT_MAX) gc_bases++;
      default: ;
    endcase
  endfunction

  function automatic void close_line();
    int unsigned       total;
    int unsigned       frac;
    int unsigned       w;
    int unsigned       s;
    longint unsigned   start;
    logic [7:0]        old_slot;
    window_avg_t       r;
    total = at_bases + gc_bases;
    frac  = (total != 0) ? ({gc_bases, 16'b0} / total) : 0;
    w     = span_lines();
    s     = stride_lines();
    if (line_idx >= w) begin
      start = line_idx - w;
      if (phase_cnt == 0) begin
        r.start_line    = start[OUT_LINE_W-1:0];
        r.base_position = OUT_BASE_W'(start * bpl_reg);
        r.gc_average    = OUT_AVG_W'(frac_sum / w);
        pending_avgs.push_back(r);
      end
      phase_cnt = (phase_cnt + 1 >= s) ? '0 : phase_cnt + 1'b1;
      // line leaving the window; w of 256 lands on the head slot itself
      old_slot = ring_head - 8'(w);
      frac_sum = frac_sum - frac_ring[old_slot];
    end
    frac_ring[ring_head] = frac[OUT_AVG_W-1:0];
    frac_sum  = frac_sum + frac;
    ring_head = ring_head + 1'b1;
    if (line_idx != LINE_SAT) line_idx++;
    at_bases = '0;
    gc_bases = '0;
  endfunction

  function automatic void check_field(string field, logic [OUT_BASE_W-1:0] want,
                                      logic [OUT_BASE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    window_avg_t want;
    if (!rst_n) begin
      window_reg = RST_WINDOW;
      step_reg   = RST_STEP;
      bpl_reg    = RST_BPL;
      at_bases   = '0;
      gc_bases   = '0;
      clear_windowing();
      pending_avgs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_avgs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got start %0d base %0d avg %0d",
                   $time, out_start_line, out_base_position, out_gc_average);
        end else begin
          want = pending_avgs.pop_front();
          check_field("window_start_line", want.start_line, out_start_line);
          check_field("base_position", want.base_position, out_base_position);
          check_field("gc_average", want.gc_average, out_gc_average);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: begin
            window_reg = cfg_data[8:0];
            clear_windowing();
          end
          REG_STEP: step_reg = cfg_data[8:0];
          REG_BPL:  bpl_reg  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_EOL) close_line();
        else count_base(in_symbol);
      end
    end
    fail_count  <= errors;
    windows_due <= pending_avgs.size();
  end

endmodule

[bench/tb_top.sv]
// Top of the GC content window bench: clock, reset, line stimulus, settings and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gcw_pkg::*;

  // Cycles with no item moving on either channel before the run is declared hung
  localparam int QUIET_LIMIT   = 5000;
  // Settle time after a drain: the back end queues two line ends; this covers them with margin
  localparam int SETTLE_CYCLES = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int windows_due;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int quiet_cycles    = 0;
  int phase_no        = 0;

  gcw_in_if  in_ch ();
  gcw_out_if out_ch ();

  gc_content_window uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gc_window_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_command        (in_ch.command),
    .in_symbol         (in_ch.symbol),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_start_line    (out_ch.window_start_line),
    .out_base_position (out_ch.base_position),
    .out_gc_average    (out_ch.gc_average),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .windows_due       (windows_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure at the current stall rate
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hang watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle modes rotate per phase: none, sender gaps, receiver stalls, light both
  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      1: begin
        sender_idle_pct = 73;
        recv_stall_pct  = 0;
      end
      2: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 73;
      end
      default: begin
        sender_idle_pct = 19;
        recv_stall_pct  = 19;
      end
    endcase
  endtask

  // One item: optional gap cycles, then hold valid until the block takes it.
  // valid is never dropped and raised in one step.
  task automatic send_item(logic cmd, logic [SYMBOL_W-1:0] sym);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.symbol  <= sym;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_SYMBOL, s[i]);
  endtask

  // Stop sending until every predicted window is out, then wait extra cycles.
  // A clock edge always passes first, so valid is not re-raised in the same step.
  task automatic drain(int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (windows_due != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Registers change only with the block idle; any subset may be written
  task automatic configure(bit wr_w, logic [8:0] w, bit wr_s, logic [8:0] s,
                           bit wr_b, logic [8:0] b);
    drain(SETTLE_CYCLES);
    if (wr_w) write_reg(REG_WINDOW, w);
    if (wr_s) write_reg(REG_STEP, s);
    if (wr_b) write_reg(REG_BPL, b);
    cfg_we <= 1'b0;
  endtask

  // A line of n characters (gc_pct percent G/C, random case) with noise bytes mixed in
  task automatic send_line(int n_chars, int gc_pct, int noise_pct);
    logic [SYMBOL_W-1:0] sym;
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        sym = 8'($urandom_range(0, 255));
      end else begin
        if ($urandom_range(0, 99) < gc_pct) sym = $urandom_range(0, 1) ? "G" : "C";
        else sym = $urandom_range(0, 1) ? "A" : "T";
        if ($urandom_range(0, 1)) sym = sym | 8'h20;
      end
      send_item(CMD_SYMBOL, sym);
    end
    send_item(CMD_EOL, 8'($urandom_range(0, 255)));
  endtask

  // Mostly short mixed lines; some pure GC or pure AT, a few long enough to
  // saturate the base counters, and an occasional pause for a full drain.
  // With max_len 0 the mixed lines are empty and the pure ones hold at most
  // one base.
  task automatic run_phase(int n_lines, int max_len, int long_pct);
    int pick;
    set_idling(phase_no);
    phase_no++;
    repeat (n_lines) begin
      pick = $urandom_range(0, 99);
      if (pick < long_pct) begin
        send_line($urandom_range(256, 280), $urandom_range(0, 100), 5);
      end else if (pick < long_pct + 6) begin
        send_line($urandom_range(1, max_len), 100, 0);
      end else if (pick < long_pct + 12) begin
        send_line($urandom_range(1, max_len), 0, 0);
      end else begin
        send_line($urandom_range(0, max_len), $urandom_range(0, 100), 15);
      end
      if ($urandom_range(0, 99) < 3) drain(0);
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_SYMBOL;
    in_ch.symbol  = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WINDOW;
    cfg_data      = '0;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines at the reset settings (window 10, step 20, 80 bases):
    // no window is complete yet, so these only feed the first averages.
    send_text("AcGt");                // mixed case, half GC
    send_item(CMD_EOL, 8'hFF);
    send_item(CMD_EOL, 8'h00);        // empty line: fraction zero
    send_text("GgCc");                // all GC: fraction exactly one
    send_item(CMD_EOL, "A");          // symbol is ignored on a line end
    send_item(CMD_SYMBOL, 8'h00);     // non-bases only, incl. high-bit codes
    send_item(CMD_SYMBOL, 8'hFF);
    send_item(CMD_SYMBOL, 8'hC7);     // 'G' with bit 7 set: not a base
    send_text("eN");
    send_item(CMD_EOL, 8'h55);
    send_text("TaA");                 // all AT
    send_item(CMD_EOL, 8'h00);
    send_text("Gat");                 // one third
    send_item(CMD_EOL, 8'hAA);

    // Still at reset settings: results at lines 10 and 30 check the defaults
    run_phase(25, 3, 0);

    // Window 1, step 1: every line end after the first yields the previous line's fraction; widest scale
    configure(1'b1, 9'd1, 1'b1, 9'd1, 1'b1, 9'd255);
    run_phase(12, 3, 0);

    // Zero window and step act as one; zero bases per line gives position 0
    configure(1'b1, 9'd0, 1'b1, 9'd0, 1'b1, 9'd0);
    run_phase(10, 3, 0);

    // Window above the maximum clamps to 256; the ring wraps with the oldest
    // slot equal to the write slot
    configure(1'b1, 9'h1FF, 1'b1, 9'd1, 1'b1, 9'd1);
    run_phase(259, 0, 0);

    // Partial line left open across a window restart keeps its counts.
    // Widest step: only the window starting at line 0 is reported.
    send_text("cT");
    configure(1'b1, 9'd3, 1'b1, 9'd256, 1'b0, 9'd0);
    run_phase(8, 2, 0);

    // Step above the maximum, written mid-stream; bit 8 of the scale is dropped
    configure(1'b0, 9'd0, 1'b1, 9'h1C0, 1'b1, 9'h1AB);
    run_phase(4, 2, 0);

    // Step shrinks below the running phase: the phase wraps to zero
    configure(1'b0, 9'd0, 1'b1, 9'd2, 1'b0, 9'd0);
    run_phase(6, 2, 0);

    drain(SETTLE_CYCLES);
    @(negedge clk);
    if (fail_count == 0 && windows_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
